// ===== design/slst_pkg.sv =====
// Shared constants for the stroke length and speed tracker.
// Used by the top level and by the compare/subtract unit; depends on nothing.
package slst_pkg;

	// Fixed field widths of the result.
	localparam int LEN_W = 40;
	localparam int SPD_W = 32;

	// Pen point fields.
	localparam int COORD_W = 16;
	localparam int STAMP_W = 32;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index decoded from paddr[2].
	localparam logic REG_SPEED_STILL = 1'b0;

	localparam logic [SPD_W-1:0] SPEED_STILL_RST = {SPD_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [SPD_W-1:0] SPD_MAX = {SPD_W{1'b1}};

	// Output of the shared compare/subtract unit, the flag part.
	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_flags_t;

endpackage

// ===== design/slst_cmpsub.sv =====
// Shared compare/subtract unit of the stroke length and speed tracker.
// Depends on slst_pkg for the flag struct.
module slst_cmpsub #(
	parameter int W = 35
) (
	input  logic [W-1:0]            a,
	input  logic [W-1:0]            b,
	output logic [W-1:0]            diff,
	output slst_pkg::cmp_flags_t    flags
);

	logic [W:0] full;

	// The borrow out of the subtraction tells whether a is below b.
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign flags.ge = ~full[W];
	assign flags.eq = (a == b);

endmodule

// ===== design/stroke_length_speed_tracker.sv =====
// Top level of the stroke length and speed tracker: APB register, stream ports,
// sequencer and datapath. Depends on slst_pkg and slst_cmpsub.
//
// Channel   | Direction | Handshake         | Contents
// s_*       | in        | s_tvalid/s_tready | one pen point (x, y, time stamp, stroke start)
// m_*       | out       | m_tvalid/m_tready | path length, average speed, no-time flag
// APB       | in/out    | psel/penable      | speed_when_still register at byte address 0
//
// A point that opens a stroke goes straight to delivery. A continuing point runs the
// squares, 17 + LENGTH_FRAC_BITS root digits, the length add, a range check, 32
// quotient bits and delivery; the divide is skipped when no time has elapsed or the
// speed saturates. The root digits, range check and quotient bits share the one
// compare/subtract unit. The input is not ready while a point is in work; a result
// that waits in the output register stalls the delivery step and so the input. Reset
// clears all control state and sets the register to all ones.
module stroke_length_speed_tracker #(
	parameter int LENGTH_FRAC_BITS = 8,
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [slst_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [slst_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [slst_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// Pen point requests
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [63:0]                         s_tdata,  // pos_x, pos_y, stamp_ms
	input  logic                                s_tuser,  // first_point
	// Results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [71:0]                         m_tdata,  // path_length, avg_speed
	output logic                                m_tuser   // speed_is_still
);

	localparam int LEN_W = slst_pkg::LEN_W;
	localparam int SPD_W = slst_pkg::SPD_W;
	localparam int CW_X = slst_pkg::COORD_W;
	localparam int ST_W = slst_pkg::STAMP_W;

	// Square root: one result bit per digit pair, fraction pairs are zero.
	localparam int NPAIRS = 17 + LENGTH_FRAC_BITS;
	localparam int RTW = NPAIRS;
	localparam int RW = RTW + 2;
	localparam int SQ_W = 2 * CW_X + 1;
	localparam int SQSH_W = 2 * NPAIRS;

	// The divide runs on the length rescaled to the speed's fraction bits.
	localparam int SHIFT = SPEED_FRAC_BITS - LENGTH_FRAC_BITS;
	localparam int SHL = (SHIFT >= 0) ? SHIFT : 0;
	localparam int SHR = (SHIFT < 0) ? -SHIFT : 0;
	localparam int NUM_W = 2 * SPD_W;

	localparam int AW = (RW > SPD_W + 1) ? RW : SPD_W + 1;
	localparam int CNT_W = ($clog2(NPAIRS) > 5) ? $clog2(NPAIRS) : 5;

	// Sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MULX   = 4'd1;
	localparam logic [3:0] ST_MULY   = 4'd2;
	localparam logic [3:0] ST_ADD    = 4'd3;
	localparam logic [3:0] ST_ROOT   = 4'd4;
	localparam logic [3:0] ST_LEN    = 4'd5;
	localparam logic [3:0] ST_DIVCHK = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]             state_q;
	logic [SPD_W-1:0]       spd_still_q;
	logic                   started_q;
	logic [ST_W-1:0]        start_q;
	logic [CW_X-1:0]        prev_x_q;
	logic [CW_X-1:0]        prev_y_q;
	logic [LEN_W-1:0]       len_q;
	logic [CW_X-1:0]        ax_q;
	logic [CW_X-1:0]        ay_q;
	logic [ST_W-1:0]        elapsed_q;
	logic [2*CW_X-1:0]      prod_q;
	logic [SQ_W-1:0]        sq_q;
	logic [SQSH_W-1:0]      sqsh_q;
	logic [RW-1:0]          rem_q;
	logic [RTW-1:0]         root_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SPD_W-1:0]       div_rem_q;
	logic [SPD_W-1:0]       div_num_q;
	logic [SPD_W-1:0]       quo_q;
	logic [SPD_W-1:0]       res_spd_q;
	logic                   res_still_q;
	logic                   m_tvalid_q;
	logic [LEN_W-1:0]       out_len_q;
	logic [SPD_W-1:0]       out_spd_q;
	logic                   out_still_q;

	logic                   cfg_wr;
	logic                   in_acc;
	logic signed [CW_X:0]   dx;
	logic signed [CW_X:0]   dy;
	logic [CW_X:0]          dx_abs;
	logic [CW_X:0]          dy_abs;
	logic [CW_X-1:0]        mul_op;
	logic [2*CW_X-1:0]      mul_res;
	logic [1:0]             pair;
	logic [RW-1:0]          rem_next;
	logic [SPD_W:0]         div_next;
	logic [LEN_W:0]         len_sum;
	logic [NUM_W-1:0]       num_full;
	logic [AW-1:0]          alu_a;
	logic [AW-1:0]          alu_b;
	logic [AW-1:0]          alu_diff;
	slst_pkg::cmp_flags_t   alu_flags;

	// Configuration register. Only paddr[2] selects a register; the byte
	// offset bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == slst_pkg::REG_SPEED_STILL) ? spd_still_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_still_q <= slst_pkg::SPEED_STILL_RST;
		end else if (cfg_wr && paddr[2] == slst_pkg::REG_SPEED_STILL) begin
			spd_still_q <= pwdata;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid & s_tready;

	// Coordinate differences against the previous point; the magnitude of a
	// 17-bit difference of two 16-bit values always fits in 16 bits.
	assign dx = signed'({s_tdata[15], s_tdata[15:0]}) - signed'({prev_x_q[15], prev_x_q});
	assign dy = signed'({s_tdata[31], s_tdata[31:16]}) - signed'({prev_y_q[15], prev_y_q});
	assign dx_abs = dx[CW_X] ? unsigned'(-dx) : unsigned'(dx);
	assign dy_abs = dy[CW_X] ? unsigned'(-dy) : unsigned'(dy);

	// One 16x16 multiplier squares x then y.
	assign mul_op = (state_q == ST_MULX) ? ax_q : ay_q;
	assign mul_res = mul_op * mul_op;

	// Root step: bring down the next digit pair and try the odd trial value.
	assign pair = sqsh_q[SQSH_W-1 -: 2];
	assign rem_next = {rem_q[RTW-1:0], pair};

	// Divide step: bring down the next numerator bit.
	assign div_next = {div_rem_q, div_num_q[SPD_W-1]};

	assign len_sum = {1'b0, len_q} + (LEN_W+1)'(root_q);
	assign num_full = (NUM_W'(len_q) << SHL) >> SHR;

	always_comb begin
		case (state_q)
			ST_ROOT: begin
				alu_a = AW'(rem_next);
				alu_b = AW'({root_q, 2'b01});
			end
			ST_DIVCHK: begin
				alu_a = AW'(num_full[NUM_W-1:SPD_W]);
				alu_b = AW'(elapsed_q);
			end
			ST_DIV: begin
				alu_a = AW'(div_next);
				alu_b = AW'(elapsed_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	slst_cmpsub #(
		.W(AW)
	) u_cmpsub (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.flags(alu_flags)
	);

	// Sequencer and stroke state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			start_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			len_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may replace one that leaves in the same cycle.
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_x_q <= s_tdata[15:0];
						prev_y_q <= s_tdata[31:16];
						if (s_tuser || !started_q) begin
							started_q <= 1'b1;
							start_q <= s_tdata[63:32];
							len_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MULX;
						end
					end
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					// The length sticks at its maximum once it overflows.
					len_q <= len_sum[LEN_W] ? slst_pkg::LEN_MAX : len_sum[LEN_W-1:0];
					state_q <= (elapsed_q == '0) ? ST_DONE : ST_DIVCHK;
				end
				ST_DIVCHK: begin
					state_q <= alu_flags.ge ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= dx_abs[CW_X-1:0];
				ay_q <= dy_abs[CW_X-1:0];
				elapsed_q <= s_tdata[63:32] - start_q;
				res_spd_q <= '0;
				res_still_q <= 1'b0;
			end
			ST_MULX: begin
				prod_q <= mul_res;
			end
			ST_MULY: begin
				sq_q <= SQ_W'(prod_q);
				prod_q <= mul_res;
			end
			ST_ADD: begin
				sqsh_q <= SQSH_W'(sq_q + SQ_W'(prod_q)) << (2 * LENGTH_FRAC_BITS);
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= CNT_W'(NPAIRS - 1);
			end
			ST_ROOT: begin
				sqsh_q <= sqsh_q << 2;
				rem_q <= alu_flags.ge ? alu_diff[RW-1:0] : rem_next;
				root_q <= {root_q[RTW-2:0], alu_flags.ge};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_LEN: begin
				if (elapsed_q == '0) begin
					res_spd_q <= spd_still_q;
					res_still_q <= 1'b1;
				end
			end
			ST_DIVCHK: begin
				// A quotient that does not fit in 32 bits saturates at once.
				if (alu_flags.ge) begin
					res_spd_q <= slst_pkg::SPD_MAX;
				end
				div_rem_q <= num_full[NUM_W-1:SPD_W];
				div_num_q <= num_full[SPD_W-1:0];
				quo_q <= '0;
				cnt_q <= CNT_W'(SPD_W - 1);
			end
			ST_DIV: begin
				div_rem_q <= alu_flags.ge ? alu_diff[SPD_W-1:0] : div_next[SPD_W-1:0];
				div_num_q <= div_num_q << 1;
				quo_q <= {quo_q[SPD_W-2:0], alu_flags.ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					res_spd_q <= {quo_q[SPD_W-2:0], alu_flags.ge};
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_len_q <= len_q;
					out_spd_q <= res_spd_q;
					out_still_q <= res_still_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_spd_q, out_len_q};
	assign m_tuser = out_still_q;

`ifndef SYNTHESIS
	// A point that opens a stroke goes straight to delivery.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser || !started_q) |=> state_q == ST_DONE)
		else $error("stroke start did not go to delivery");

	// A continuing point starts with the squares.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_tuser && started_q |=> state_q == ST_MULX)
		else $error("continuing point did not start the squares");

	// The partial remainder of the divide stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_rem_q < elapsed_q)
		else $error("divide remainder out of range");

	// The divide is never entered with no elapsed time.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVCHK || state_q == ST_DIV |-> elapsed_q != '0)
		else $error("divide entered with zero elapsed time");
`endif

endmodule

// ===== test/tb_stroke_length_speed_tracker.sv =====
// Self-checking testbench for the stroke length and speed tracker.
// Depends on slst_pkg and the stroke_length_speed_tracker RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_stroke_length_speed_tracker;

	// The block is built at its default fixed-point formats. The speed predictor
	// below assumes SPEED_FRAC_BITS >= LENGTH_FRAC_BITS, which holds here.
	localparam int LENGTH_FRAC_BITS = 8;
	localparam int SPEED_FRAC_BITS  = 16;
	localparam int SPEED_SHIFT      = SPEED_FRAC_BITS - LENGTH_FRAC_BITS;
	localparam int ROOT_DIGITS      = 17 + LENGTH_FRAC_BITS;

	// Register map: speed_when_still sits at byte address 0. The other word
	// address decodes to no register, so a write there must change nothing.
	localparam logic [slst_pkg::APB_ADDR_W-1:0] ADDR_SPEED_STILL =
		{slst_pkg::REG_SPEED_STILL, 2'b00};
	localparam logic [slst_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
		{~slst_pkg::REG_SPEED_STILL, 2'b00};

	// Run control. The watchdog limit covers the long receiver hold plus one point in
	// work, with generous slack for random gaps on both sides.
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int HOLD_CYCLES    = 900;
	localparam int SETTLE_CYCLES  = 70;

	// One pen point request and one result, at the block's widths.
	typedef struct packed {
		logic                                first;
		logic signed [slst_pkg::COORD_W-1:0] x;
		logic signed [slst_pkg::COORD_W-1:0] y;
		logic [slst_pkg::STAMP_W-1:0]        stamp;
	} point_t;

	typedef struct packed {
		logic [slst_pkg::LEN_W-1:0] length;
		logic [slst_pkg::SPD_W-1:0] speed;
		logic                       still;
	} result_t;

	// A directed row: the point, and a typed-in result where it is obvious.
	typedef struct packed {
		point_t  pt;
		logic    typed;
		result_t want;
	} row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [slst_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [slst_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [slst_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [63:0]                     s_tdata = '0;   // pos_x, pos_y, stamp_ms
	logic                            s_tuser = 1'b0; // first_point
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [71:0]                     m_tdata;        // path_length, avg_speed
	logic                            m_tuser;        // speed_is_still

	stroke_length_speed_tracker #(
		.LENGTH_FRAC_BITS(LENGTH_FRAC_BITS),
		.SPEED_FRAC_BITS(SPEED_FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Tracker state as the testbench sees it, plus the register copy.
	logic                                trk_open;
	logic [slst_pkg::STAMP_W-1:0]        trk_start;
	logic signed [slst_pkg::COORD_W-1:0] trk_prev_x;
	logic signed [slst_pkg::COORD_W-1:0] trk_prev_y;
	logic [slst_pkg::LEN_W-1:0]          trk_len;
	logic [slst_pkg::SPD_W-1:0]          still_speed;

	// Results that accepted points still owe, oldest first.
	result_t owed_results[$];
	row_t    stroke_table[$];

	// Cursor of the random stroke generator.
	logic signed [slst_pkg::COORD_W-1:0] cur_x;
	logic signed [slst_pkg::COORD_W-1:0] cur_y;
	logic [slst_pkg::STAMP_W-1:0]        cur_t;
	int                                  stroke_left;

	// Idling controls. The sender side is read only by the main process; the
	// receiver side is handed over with nonblocking writes.
	int   send_pct;
	int   recv_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	int mismatches = 0;
	int points_sent = 0;
	int strokes_opened = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int idle_cycles = 0;

	result_t got_res;
	result_t want_res;

	function automatic void note_miss(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
			$time, what, want, got);
	endfunction

	// Floor of sqrt(sq * 4^LENGTH_FRAC_BITS), one result bit per step, the
	// way a restoring square root works: the low digit pairs are zeros, which
	// supplies the fraction bits.
	function automatic logic [63:0] scaled_root(input logic [63:0] sq);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] trial;
		logic [63:0] pair;
		int          i;
		rem = '0;
		root = '0;
		for (i = ROOT_DIGITS - 1; i >= 0; i--) begin
			pair = (i >= LENGTH_FRAC_BITS) ? ((sq >> (2 * (i - LENGTH_FRAC_BITS))) & 64'd3) : '0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			root = root << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 64'd1;
			end
		end
		return root;
	endfunction

	// Length in Q.LENGTH_FRAC_BITS over elapsed milliseconds, returned in
	// Q.SPEED_FRAC_BITS, truncated, saturating at the top of the speed field.
	function automatic logic [slst_pkg::SPD_W-1:0] average_speed(input logic [63:0] len,
		input logic [63:0] elapsed);
		logic [63:0] quo;
		logic [63:0] rmd;
		logic [63:0] val;
		quo = len / elapsed;
		rmd = len % elapsed;
		if (quo > (64'(slst_pkg::SPD_MAX) >> SPEED_SHIFT))
			return slst_pkg::SPD_MAX;
		val = (quo << SPEED_SHIFT) + ((rmd << SPEED_SHIFT) / elapsed);
		return (val > 64'(slst_pkg::SPD_MAX)) ? slst_pkg::SPD_MAX : val[slst_pkg::SPD_W-1:0];
	endfunction

	// Advances the tracker copy by one point and returns the result it owes.
	function automatic result_t track_point(input point_t pt);
		result_t                      res;
		int                           dx;
		int                           dy;
		logic [63:0]                  ax;
		logic [63:0]                  ay;
		logic [63:0]                  grown;
		logic [slst_pkg::STAMP_W-1:0] elapsed;
		res = '0;
		if (pt.first || !trk_open) begin
			// A new stroke: length starts over and speed reads zero.
			trk_open = 1'b1;
			trk_start = pt.stamp;
			trk_len = '0;
		end else begin
			dx = int'(pt.x) - int'(trk_prev_x);
			dy = int'(pt.y) - int'(trk_prev_y);
			ax = 64'((dx < 0) ? -dx : dx);
			ay = 64'((dy < 0) ? -dy : dy);
			grown = 64'(trk_len) + scaled_root(ax * ax + ay * ay);
			trk_len = (grown > 64'(slst_pkg::LEN_MAX)) ? slst_pkg::LEN_MAX :
				grown[slst_pkg::LEN_W-1:0];
			// Elapsed time wraps, so a stamp that goes back reads as a long time.
			elapsed = pt.stamp - trk_start;
			if (elapsed == '0) begin
				res.speed = still_speed;
				res.still = 1'b1;
			end else begin
				res.speed = average_speed(64'(trk_len), 64'(elapsed));
			end
		end
		trk_prev_x = pt.x;
		trk_prev_y = pt.y;
		res.length = trk_len;
		return res;
	endfunction

	function automatic void add_row(input logic first, input int x, input int y,
		input logic [slst_pkg::STAMP_W-1:0] stamp, input logic typed,
		input logic [slst_pkg::LEN_W-1:0] len, input logic [slst_pkg::SPD_W-1:0] spd,
		input logic still);
		row_t r;
		r.pt.first = first;
		r.pt.x = slst_pkg::COORD_W'(x);
		r.pt.y = slst_pkg::COORD_W'(y);
		r.pt.stamp = stamp;
		r.typed = typed;
		r.want.length = len;
		r.want.speed = spd;
		r.want.still = still;
		stroke_table.push_back(r);
	endfunction

	// Random points: mostly pen-like strokes that move a little and let time
	// run forward, with jumps, reversed stamps, repeated stamps and pure noise.
	function automatic point_t next_random_point();
		point_t pt;
		int     pick;
		pick = $urandom_range(99, 0);
		if (stroke_left <= 0 || pick < 4) begin
			stroke_left = $urandom_range(24, 1);
			pt.first = 1'b1;
			if (pick < 50) begin
				cur_x = slst_pkg::COORD_W'($urandom);
				cur_y = slst_pkg::COORD_W'($urandom);
			end else begin
				cur_x = slst_pkg::COORD_W'($urandom_range(400, 0)) - slst_pkg::COORD_W'(200);
				cur_y = slst_pkg::COORD_W'($urandom_range(400, 0)) - slst_pkg::COORD_W'(200);
			end
			cur_t = $urandom;
		end else begin
			pt.first = 1'b0;
			if (pick < 70) begin
				cur_x = cur_x + slst_pkg::COORD_W'($urandom_range(80, 0)) - slst_pkg::COORD_W'(40);
				cur_y = cur_y + slst_pkg::COORD_W'($urandom_range(80, 0)) - slst_pkg::COORD_W'(40);
				cur_t = cur_t + $urandom_range(30, 0);
			end else if (pick < 80) begin
				cur_x = slst_pkg::COORD_W'($urandom);
				cur_y = slst_pkg::COORD_W'($urandom);
				cur_t = cur_t + $urandom_range(3, 0);
			end else if (pick < 87) begin
				cur_x = cur_x + slst_pkg::COORD_W'($urandom_range(8, 0)) - slst_pkg::COORD_W'(4);
				cur_t = cur_t - $urandom_range(1000, 1);
			end else if (pick < 93) begin
				cur_y = cur_y + slst_pkg::COORD_W'($urandom_range(8, 0)) - slst_pkg::COORD_W'(4);
			end else begin
				cur_x = slst_pkg::COORD_W'($urandom);
				cur_y = slst_pkg::COORD_W'($urandom);
				cur_t = $urandom;
			end
		end
		stroke_left--;
		pt.x = cur_x;
		pt.y = cur_y;
		pt.stamp = cur_t;
		return pt;
	endfunction

	// Offers one point request, idling first if the phase asks for it, and
	// books the owed result once the block takes it. Valid is never lowered
	// and raised in the same step: the idle loop waits for the clock after each write.
	task automatic send_point(input point_t pt, input logic typed, input result_t want);
		result_t model;
		while ($urandom_range(99, 0) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pt.stamp, pt.y, pt.x};
		s_tuser <= pt.first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// The tracker copy moves on every row; a typed row overrides only what
		// is checked, so a bad predictor shows up against the typed values.
		model = track_point(pt);
		owed_results.push_back(typed ? want : model);
		points_sent++;
		if (pt.first)
			strokes_opened++;
	endtask

	task automatic reg_write(input logic [slst_pkg::APB_ADDR_W-1:0] addr,
		input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_SPEED_STILL)
			still_speed = value;
		reg_writes++;
	endtask

	task automatic reg_readback();
		logic [31:0] seen;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SPEED_STILL;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		seen = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (seen !== still_speed)
			note_miss("speed_when_still readback", 64'(still_speed), 64'(seen));
	endtask

	task automatic random_points(input int count);
		int n;
		for (n = 0; n < count; n++)
			send_point(next_random_point(), 1'b0, '0);
	endtask

	// Stops offering, waits for every owed result, then lets the block settle
	// so that a register write lands only while it is idle.
	task automatic finish_phase();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls by phase, and once a long hold-off counted here
	// while the sender keeps pushing, so the block backs up to its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_pct);
		end
	end

	// Result checker: every accepted result against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_res.length = m_tdata[slst_pkg::LEN_W-1:0];
			got_res.speed = m_tdata[slst_pkg::LEN_W+slst_pkg::SPD_W-1:slst_pkg::LEN_W];
			got_res.still = m_tuser;
			if (owed_results.size() == 0) begin
				note_miss("unexpected result, path_length", '0, 64'(got_res.length));
			end else begin
				want_res = owed_results.pop_front();
				if (got_res.length !== want_res.length)
					note_miss("path_length", 64'(want_res.length), 64'(got_res.length));
				if (got_res.speed !== want_res.speed)
					note_miss("avg_speed", 64'(want_res.speed), 64'(got_res.speed));
				if (got_res.still !== want_res.still)
					note_miss("speed_is_still", 64'(want_res.still), 64'(got_res.still));
			end
		end
	end

	// Watchdog: too many cycles without any handshake or register access.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d results still owed",
				$time, idle_cycles, owed_results.size());
			$display("stroke_length_speed_tracker regression: fail");
			$finish;
		end
	end

	initial begin
		row_t row;
		int   k;

		trk_open = 1'b0;
		trk_start = '0;
		trk_prev_x = '0;
		trk_prev_y = '0;
		trk_len = '0;
		still_speed = slst_pkg::SPEED_STILL_RST;
		stroke_left = 0;
		cur_x = '0;
		cur_y = '0;
		cur_t = '0;
		send_pct = 0;

		// Directed strokes. The first point after reset opens a stroke even
		// without the start flag. 3-4-5 gives an exact root; diagonal steps
		// check the floor of an irrational root. Corner-to-corner in 1 ms
		// saturates the speed, and stamps that step back wrap the elapsed time.
		add_row(1'b0, 0, 0, 32'd100, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, 3, 4, 32'd100, 1'b1, slst_pkg::LEN_W'(5 << LENGTH_FRAC_BITS),
			slst_pkg::SPEED_STILL_RST, 1'b1);
		add_row(1'b0, 3, 4, 32'd101, 1'b1, slst_pkg::LEN_W'(5 << LENGTH_FRAC_BITS),
			slst_pkg::SPD_W'(5 << SPEED_FRAC_BITS), 1'b0);
		add_row(1'b1, -32768, -32768, 32'd0, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, 32767, 32767, 32'd1, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, 32767, 32767, 32'd1, 1'b0, '0, '0, 1'b0);
		add_row(1'b1, 0, 0, 32'd1000, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, -1, -1, 32'd999, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, -1, -1, 32'd1000, 1'b0, '0, '0, 1'b0);
		add_row(1'b1, 32767, 32767, 32'hFFFF_FFFF, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, 32767, 32767, 32'd0, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, 32767, -32768, 32'd2, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, -32768, -32768, 32'd3, 1'b0, '0, '0, 1'b0);
		add_row(1'b1, -32768, 32767, 32'h8000_0000, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, -32767, 32766, 32'h8000_0000, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, -32768, 32767, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
		add_row(1'b1, 1, 1, 32'd5, 1'b1, '0, '0, 1'b0);
		add_row(1'b1, 2, 2, 32'd5, 1'b1, '0, '0, 1'b0);
		add_row(1'b0, 2, 2, 32'd5, 1'b1, '0, slst_pkg::SPEED_STILL_RST, 1'b1);
		add_row(1'b0, 5, 6, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, 12345, -23456, 32'h5555_5555, 1'b0, '0, '0, 1'b0);
		add_row(1'b0, -12345, 23456, 32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0);

		// Reset is held low at the start and released on a clock edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_readback();

		// Phase one: reset register value, no idling on either side. After
		// the table, the receiver holds off once while points keep coming.
		for (k = 0; k < stroke_table.size(); k++) begin
			row = stroke_table[k];
			send_point(row.pt, row.typed, row.want);
		end
		hold_req <= 1'b1;
		random_points(400);
		finish_phase();

		// Phase two: still-speed of zero; a write to the unmapped word must
		// not disturb it. Sender idles.
		reg_write(ADDR_SPEED_STILL, 32'd0);
		reg_write(ADDR_UNMAPPED, $urandom);
		reg_readback();
		send_pct = 46;
		random_points(430);
		finish_phase();

		// Phase three: random still-speed, receiver stalls.
		reg_write(ADDR_SPEED_STILL, $urandom);
		reg_readback();
		send_pct = 0;
		recv_pct <= 46;
		random_points(430);
		finish_phase();

		// Phase four: still-speed back at all ones, both sides idle.
		reg_write(ADDR_SPEED_STILL, slst_pkg::SPD_MAX);
		reg_readback();
		send_pct = 29;
		recv_pct <= 29;
		random_points(430);
		finish_phase();

		$display("Ran %0d pen points in %0d strokes and checked %0d results,",
			points_sent, strokes_opened, results_seen);
		$display("over four idling phases with %0d register writes and a long output hold.",
			reg_writes);
		if (mismatches == 0)
			$display("stroke_length_speed_tracker regression: pass");
		else
			$display("stroke_length_speed_tracker regression: fail");
		$finish;
	end

endmodule
